// File: hdl/lsched_pkg.sv
// Shared types and constants for the lottery scheduler ticket table.
package lsched_pkg;

  localparam int ENTRIES     = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int TICKET_BITS = 16;
  localparam int TOTAL_W     = TICKET_BITS + IDX_W;
  localparam int DIV_W       = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int S_TDATA_W   = 80;
  localparam int M_TDATA_W   = 48;
  localparam int XFER_SCALE  = 9;
  localparam int XFER_DIVISOR = 10;
  // Division by ten as a multiply by a rounded-up reciprocal and a shift; exact for
  // every 9*tickets value of the total width.
  localparam int XFER_SHIFT  = 22;
  localparam int XFER_RECIP  = (2**XFER_SHIFT + XFER_DIVISOR - 1) / XFER_DIVISOR;
  localparam int XFER_PROD_W = TOTAL_W + $clog2(XFER_RECIP + 1);

  typedef logic [TICKET_BITS-1:0] ticket_t;
  typedef logic [TOTAL_W-1:0]     total_t;
  typedef logic [IDX_W-1:0]       idx_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_DRAW  = 2'd1,
    OP_XFER  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // One write into the entry table.
  typedef struct packed {
    logic    en;
    logic    elig_en;
    idx_t    addr;
    ticket_t tickets;
    logic    elig;
  } tbl_wr_t;

endpackage

// File: hdl/lsched_table.sv
// Entry table: ticket counts and eligible flags with one write and one read port.
module lsched_table
  import lsched_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  tbl_wr_t wr,
  input  idx_t    raddr,
  output ticket_t rd_tickets,
  output logic    rd_elig
);

  ticket_t tickets [ENTRIES];
  logic    elig    [ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tickets[i] <= '0;
        elig[i]    <= 1'b0;
      end
    end else if (wr.en) begin
      tickets[wr.addr] <= wr.tickets;
      if (wr.elig_en) begin
        elig[wr.addr] <= wr.elig;
      end
    end
  end

  assign rd_tickets = tickets[raddr];
  assign rd_elig    = elig[raddr];

endmodule

// File: hdl/lsched_div.sv
// Restoring divider that retires one quotient bit per cycle.
module lsched_div
  import lsched_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  total_t           divisor,
  output logic             done,
  output total_t           remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  total_t               dvs;
  logic [DIV_W-1:0]     quotient;
  logic [TOTAL_W:0]     trial;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and test it.
  assign trial = {remainder, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        dvs       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (fits) begin
          remainder <= TOTAL_W'(trial - {1'b0, dvs});
        end else begin
          remainder <= trial[TOTAL_W-1:0];
        end
        quotient <= {quotient[DIV_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/lottery_scheduler_ticket_table_unit.sv
// Top level of the lottery scheduler ticket table: sequencer, table and divider.
// Path from the accepting edge to m_tvalid: a write goes straight to S_DONE; a transfer reads
// the source, forms 9*source/10 by a reciprocal multiply when the source is short, then debits
// and credits; a draw sums the eligible tickets, waits on the divider, scans and loads.
// One item is in work at a time; s_tready rises together with m_tvalid as the result is loaded.
// Reset (rst, synchronous) clears every ticket count and eligible flag.
module lottery_scheduler_ticket_table_unit
  import lsched_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // From bit 0: entry_index[4], entry_eligible[1], entry_tickets[16],
  // random_value[32], source_index[4], dest_index[4], transfer_amount[16], zero pad.
  input  logic [S_TDATA_W-1:0] s_tdata,
  // op[2]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // From bit 0: chosen_index[4], chosen_valid[1], moved_tickets[16],
  // eligible_total[20], zero pad.
  output logic [M_TDATA_W-1:0] m_tdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DRAW_DIV,
    S_SCAN,
    S_XFER_SRC,
    S_XFER_DIV,
    S_XFER_DEBIT,
    S_XFER_CREDIT,
    S_DONE
  } state_t;

  // Input item fields.
  logic [3:0]  in_entry_index;
  logic        in_entry_eligible;
  logic [15:0] in_entry_tickets;
  logic [31:0] in_random_value;
  logic [3:0]  in_source_index;
  logic [3:0]  in_dest_index;
  logic [15:0] in_transfer_amount;
  op_t         in_op;

  assign in_entry_index     = s_tdata[3:0];
  assign in_entry_eligible  = s_tdata[4];
  assign in_entry_tickets   = s_tdata[20:5];
  assign in_random_value    = s_tdata[52:21];
  assign in_source_index    = s_tdata[56:53];
  assign in_dest_index      = s_tdata[60:57];
  assign in_transfer_amount = s_tdata[76:61];
  assign in_op              = op_t'(s_tuser);

  state_t      state;
  idx_t        idx;
  idx_t        src;
  idx_t        dst;
  total_t      total;
  total_t      run;
  total_t      draw_rem;
  ticket_t     have;
  ticket_t     moved;
  ticket_t     amount;
  logic [31:0] rnd;

  // Result being built, then the output register.
  logic [3:0]  res_idx;
  logic        res_valid;
  logic [15:0] res_moved;
  logic [19:0] res_total;
  logic [3:0]  out_idx;
  logic        out_valid_bit;
  logic [15:0] out_moved;
  logic [19:0] out_total;

  tbl_wr_t     tbl_wr;
  idx_t        raddr;
  ticket_t     rd_tickets;
  logic        rd_elig;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  total_t           div_divisor;
  logic             div_done;
  total_t           div_remainder;

  logic   accept;
  logic   last_idx;
  total_t total_next;
  total_t run_next;
  total_t scaled_have;
  logic [XFER_PROD_W-1:0] xfer_prod;
  logic   idx_ok;
  logic   xfer_ok;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign last_idx = (idx == IDX_W'(ENTRIES - 1));

  assign idx_ok  = int'(in_entry_index) < ENTRIES;
  assign xfer_ok = (int'(in_source_index) < ENTRIES) && (int'(in_dest_index) < ENTRIES);

  // Running sums over the entry walk; only eligible entries count.
  assign total_next = rd_elig ? total + TOTAL_W'(rd_tickets) : total;
  assign run_next   = rd_elig ? run + TOTAL_W'(rd_tickets) : run;

  // 9*have by shift and add; it fits the total width.
  assign scaled_have = (TOTAL_W'(have) << 3) + TOTAL_W'(have);

  // Dividing by ten: multiply by the reciprocal, keep the bits above the shift.
  assign xfer_prod = XFER_PROD_W'(scaled_have) * XFER_PROD_W'(XFER_RECIP);

  // The table has one read address; the sequencer points it where it needs.
  always_comb begin
    unique case (state)
      S_XFER_SRC:    raddr = src;
      S_XFER_CREDIT: raddr = dst;
      default:       raddr = idx;
    endcase
  end

  // Table write port: entry writes come straight from the accepted item, transfer
  // debit and credit come from the sequencer and leave the eligible flag alone.
  always_comb begin
    tbl_wr = '0;
    if (accept && (in_op == OP_WRITE) && idx_ok) begin
      tbl_wr.en      = 1'b1;
      tbl_wr.elig_en = 1'b1;
      tbl_wr.addr    = IDX_W'(in_entry_index);
      tbl_wr.tickets = TICKET_BITS'(in_entry_tickets);
      tbl_wr.elig    = in_entry_eligible;
    end else if (state == S_XFER_DEBIT) begin
      tbl_wr.en      = 1'b1;
      tbl_wr.addr    = src;
      tbl_wr.tickets = have - moved;
    end else if (state == S_XFER_CREDIT) begin
      tbl_wr.en   = 1'b1;
      tbl_wr.addr = dst;
      // The destination saturates at the largest ticket count.
      if ({1'b0, rd_tickets} + {1'b0, moved} > {1'b0, {TICKET_BITS{1'b1}}}) begin
        tbl_wr.tickets = {TICKET_BITS{1'b1}};
      end else begin
        tbl_wr.tickets = rd_tickets + moved;
      end
    end
  end

  // The divider serves the draw: random value mod total, started as the sum completes.
  always_comb begin
    div_start    = (state == S_SUM) && last_idx && (total_next != '0);
    div_dividend = rnd;
    div_divisor  = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      m_tvalid      <= 1'b0;
      out_idx       <= '0;
      out_valid_bit <= 1'b0;
      out_moved     <= '0;
      out_total     <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_idx   <= '0;
            res_valid <= 1'b0;
            res_moved <= '0;
            res_total <= '0;
            idx       <= '0;
            total     <= '0;
            run       <= '0;
            rnd       <= in_random_value;
            src       <= IDX_W'(in_source_index);
            dst       <= IDX_W'(in_dest_index);
            amount    <= TICKET_BITS'(in_transfer_amount);
            unique case (in_op)
              OP_DRAW: state <= S_SUM;
              OP_XFER: state <= xfer_ok ? S_XFER_SRC : S_DONE;
              default: state <= S_DONE;
            endcase
          end
        end
        S_SUM: begin
          total <= total_next;
          idx   <= idx + 1'b1;
          if (last_idx) begin
            // A zero total leaves the all-zero result in place.
            state <= (total_next != '0) ? S_DRAW_DIV : S_DONE;
          end
        end
        S_DRAW_DIV: begin
          if (div_done) begin
            draw_rem  <= div_remainder;
            res_total <= 20'(total);
            idx       <= '0;
            run       <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          run <= run_next;
          idx <= idx + 1'b1;
          // First eligible entry whose running sum passes the remainder wins.
          if (rd_elig && (run_next > draw_rem)) begin
            res_idx   <= 4'(idx);
            res_valid <= 1'b1;
            state     <= S_DONE;
          end else if (last_idx) begin
            state <= S_DONE;
          end
        end
        S_XFER_SRC: begin
          have <= rd_tickets;
          if (rd_tickets < amount) begin
            state <= S_XFER_DIV;
          end else begin
            moved <= amount;
            state <= S_XFER_DEBIT;
          end
        end
        S_XFER_DIV: begin
          moved <= xfer_prod[XFER_SHIFT +: TICKET_BITS];
          state <= S_XFER_DEBIT;
        end
        S_XFER_DEBIT: begin
          state <= S_XFER_CREDIT;
        end
        S_XFER_CREDIT: begin
          res_moved <= 16'(moved);
          state     <= S_DONE;
        end
        S_DONE: begin
          // Hand the result to the output register once it is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid      <= 1'b1;
            out_idx       <= res_idx;
            out_valid_bit <= res_valid;
            out_moved     <= res_moved;
            out_total     <= res_total;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'b0, out_total, out_moved, out_valid_bit, out_idx};

  lsched_table u_table (
    .clk        (clk),
    .rst        (rst),
    .wr         (tbl_wr),
    .raddr      (raddr),
    .rd_tickets (rd_tickets),
    .rd_elig    (rd_elig)
  );

  lsched_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_remainder)
  );

endmodule
